// File: rtl/dtt_pkg.sv
// Shared types and constants of the deadline timer table.
package dtt_pkg;

	localparam int DEPTH     = 16;
	localparam int DL_W      = 48;
	localparam int DELAY_W   = 16;
	localparam int KEY_W     = 16;
	localparam int ARG_W     = 32;
	localparam int STAT_W    = 3;
	localparam int RCNT_W    = 5;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int CS_W      = 14;
	localparam int PROD_W    = DELAY_W + CS_W;

	localparam logic [CS_W-1:0] US_PER_CS = CS_W'(10000);

	localparam logic [1:0] ACT_SCHED  = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_RUN    = 2'd2;

	localparam logic [STAT_W-1:0] STAT_SCHEDULED = 3'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
	localparam logic [STAT_W-1:0] STAT_REMOVED   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FIRED     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;
	localparam logic [STAT_W-1:0] STAT_NONE_DUE  = 3'd5;

	typedef struct packed {
		logic             valid;
		logic [DL_W-1:0]  deadline;
		logic [KEY_W-1:0] key;
		logic [ARG_W-1:0] arg;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic delete;
		logic run_mode;
	} cell_ctl_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [KEY_W-1:0]  fired_key;
		logic [ARG_W-1:0]  fired_arg;
		logic [RCNT_W-1:0] removed_count;
		logic              last;
	} rsp_t;

endpackage

// File: rtl/dtt_if.sv
// Valid/ready channel interfaces for command and result beats.
interface dtt_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   action;
	logic [dtt_pkg::DL_W-1:0]     now_us;
	logic [dtt_pkg::DELAY_W-1:0]  delay_cs;
	logic [dtt_pkg::KEY_W-1:0]    key;
	logic [dtt_pkg::ARG_W-1:0]    arg;

	modport source (output valid, action, now_us, delay_cs, key, arg, input ready);
	modport sink   (input valid, action, now_us, delay_cs, key, arg, output ready);
endinterface

interface dtt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [dtt_pkg::STAT_W-1:0]   status;
	logic [dtt_pkg::KEY_W-1:0]    fired_key;
	logic [dtt_pkg::ARG_W-1:0]    fired_arg;
	logic [dtt_pkg::RCNT_W-1:0]   removed_count;
	logic                         last;

	modport source (output valid, status, fired_key, fired_arg, removed_count, last,
		input ready);
	modport sink   (input valid, status, fired_key, fired_arg, removed_count, last,
		output ready);
endinterface

// File: rtl/dtt_cell.sv
// One timer slot of the chain: holds an entry, shifts right on insert, left on delete.
module dtt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  dtt_pkg::cell_ctl_t ctl,
	input  logic [dtt_pkg::DL_W-1:0]  now,
	input  logic [dtt_pkg::KEY_W-1:0] match_key,
	input  logic [dtt_pkg::ARG_W-1:0] match_arg,
	input  dtt_pkg::entry_t    prev_ent,
	input  dtt_pkg::entry_t    next_ent,
	input  logic               hole_in,
	output dtt_pkg::entry_t    ent,
	output logic               hole_out,
	output logic               first_hit
);
	import dtt_pkg::*;

	logic             valid_q;
	logic [DL_W-1:0]  deadline_q;
	logic [KEY_W-1:0] key_q;
	logic [ARG_W-1:0] arg_q;
	logic             match;
	logic             due;
	logic             hit;
	logic             take_next;

	assign match     = valid_q && key_q == match_key && arg_q == match_arg;
	assign due       = valid_q && deadline_q < now;
	assign hit       = ctl.run_mode ? due : match;
	assign first_hit = hit && !hole_in;
	assign hole_out  = hole_in || hit;
	// every cell at or past the first hit pulls from its right neighbor
	assign take_next = ctl.delete && hole_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			valid_q <= prev_ent.valid;
		end else if (take_next) begin
			valid_q <= next_ent.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			deadline_q <= prev_ent.deadline;
			key_q      <= prev_ent.key;
			arg_q      <= prev_ent.arg;
		end else if (take_next) begin
			deadline_q <= next_ent.deadline;
			key_q      <= next_ent.key;
			arg_q      <= next_ent.arg;
		end
	end

	assign ent = '{valid: valid_q, deadline: deadline_q, key: key_q, arg: arg_q};

endmodule

// File: rtl/deadline_timer_table_unit.sv
// Top level: sequencer, output register and the chain of timer cells.
// Schedule, remove and run beats are taken one at a time from the idle state.
// Schedule and empty-table run: result is registered directly on accept.
// Remove: the chain drops one entry per cycle, then the count is registered once the output is free.
// Run: after accept the state moves to S_RUN, then one fired result per cycle while the output is free (DEPTH max).
// Reset clears every valid flag at once; entry payload is not reset.
module deadline_timer_table_unit (
	input  logic clk,
	input  logic arst_n,
	dtt_req_if.sink   req,
	dtt_rsp_if.source rsp
);
	import dtt_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_REMOVE, S_RUN} state_t;

	state_t           state_q, state_d;
	rsp_t             out_q, out_d;
	logic             out_valid_q;
	logic             load;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [DL_W-1:0]  now_q;
	logic [KEY_W-1:0] key_q;
	logic [ARG_W-1:0] arg_q;

	logic             out_free;
	logic             accept;
	logic             full;
	logic             empty;
	logic             any_hit;
	logic             more_hits;
	logic [PROD_W-1:0] prod;
	logic [DL_W:0]    sum;
	entry_t           new_ent;
	cell_ctl_t        ctl;
	entry_t           cell_ent [DEPTH];
	entry_t           cell_next [DEPTH];
	entry_t           cell_prev [DEPTH];
	logic [DEPTH:0]   hole;
	logic [DEPTH-1:0] first;
	logic [DEPTH-1:0] vld;
	logic [KEY_W-1:0] sel_key;
	logic [ARG_W-1:0] sel_arg;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = state_q == S_IDLE && out_free;
	assign accept    = req.valid && req.ready;

	assign full  = cell_ent[DEPTH-1].valid;
	assign empty = !cell_ent[0].valid;

	// deadline = now + delay * 10000, saturated at the top of the 48-bit range
	assign prod = PROD_W'(req.delay_cs) * PROD_W'(US_PER_CS);
	assign sum  = {1'b0, req.now_us} + (DL_W + 1)'(prod);
	assign new_ent = '{valid: 1'b1, deadline: sum[DL_W] ? {DL_W{1'b1}} : sum[DL_W-1:0],
		key: req.key, arg: req.arg};

	assign hole[0] = 1'b0;
	assign any_hit = hole[DEPTH];

	always_comb begin
		sel_key = '0;
		sel_arg = '0;
		for (int i = 0; i < DEPTH; i++) begin
			vld[i] = cell_ent[i].valid;
			if (first[i]) begin
				sel_key = sel_key | cell_ent[i].key;
				sel_arg = sel_arg | cell_ent[i].arg;
			end
		end
	end

	function automatic logic cell_hit(input int idx);
		logic h;
		h = ctl.run_mode ? (cell_ent[idx].valid && cell_ent[idx].deadline < now_q) :
			(cell_ent[idx].valid && cell_ent[idx].key == key_q && cell_ent[idx].arg == arg_q);
		return h;
	endfunction

	// the first hit closes the chain's hole; any cell past it that also hits adds a beat
	always_comb begin
		more_hits = 1'b0;
		for (int i = 1; i < DEPTH; i++) begin
			if (hole[i] && cell_hit(i)) begin
				more_hits = 1'b1;
			end
		end
	end

	always_comb begin
		ctl.insert   = accept && req.action == ACT_SCHED && !full;
		ctl.run_mode = state_q == S_RUN;
		ctl.delete   = (state_q == S_REMOVE && any_hit) ||
			(state_q == S_RUN && any_hit && out_free);
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			if (g == 0) begin : g_head
				assign cell_prev[g] = new_ent;
			end else begin : g_body
				assign cell_prev[g] = cell_ent[g-1];
			end
			if (g == DEPTH - 1) begin : g_tail
				assign cell_next[g] = '0;
			end else begin : g_mid
				assign cell_next[g] = cell_ent[g+1];
			end

			dtt_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.now       (now_q),
				.match_key (key_q),
				.match_arg (arg_q),
				.prev_ent  (cell_prev[g]),
				.next_ent  (cell_next[g]),
				.hole_in   (hole[g]),
				.ent       (cell_ent[g]),
				.hole_out  (hole[g+1]),
				.first_hit (first[g])
			);
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		load    = 1'b0;
		out_d   = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.action)
						ACT_SCHED: begin
							load         = 1'b1;
							out_d.status = full ? STAT_FULL : STAT_SCHEDULED;
							out_d.last   = 1'b1;
						end
						ACT_REMOVE: begin
							cnt_d   = '0;
							state_d = S_REMOVE;
						end
						ACT_RUN: begin
							if (empty) begin
								load         = 1'b1;
								out_d.status = STAT_EMPTY;
								out_d.last   = 1'b1;
							end else begin
								state_d = S_RUN;
							end
						end
						default: ;
					endcase
				end
			end
			S_REMOVE: begin
				if (any_hit) begin
					cnt_d = cnt_q + CNT_W'(1);
				end else if (out_free) begin
					load                = 1'b1;
					out_d.status        = STAT_REMOVED;
					out_d.removed_count = RCNT_W'(cnt_q);
					out_d.last          = 1'b1;
					state_d             = S_IDLE;
				end
			end
			S_RUN: begin
				if (out_free) begin
					load = 1'b1;
					if (any_hit) begin
						out_d.status    = STAT_FIRED;
						out_d.fired_key = sel_key;
						out_d.fired_arg = sel_arg;
						out_d.last      = !more_hits;
						if (!more_hits) begin
							state_d = S_IDLE;
						end
					end else begin
						out_d.status = STAT_NONE_DUE;
						out_d.last   = 1'b1;
						state_d      = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			now_q       <= '0;
			key_q       <= '0;
			arg_q       <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load) begin
				out_valid_q <= 1'b1;
				out_q       <= out_d;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				now_q <= req.now_us;
				key_q <= req.key;
				arg_q <= req.arg;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.fired_key     = out_q.fired_key;
	assign rsp.fired_arg     = out_q.fired_arg;
	assign rsp.removed_count = out_q.removed_count;
	assign rsp.last          = out_q.last;

	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((vld + DEPTH'(1)) & vld) == '0)
		else $error("timer table lost its packed order");

	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.action == ACT_SCHED && !full) |=> vld[0])
		else $error("scheduled timer not stored at the front");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.action == ACT_RUN && empty) |=>
		(rsp.valid && rsp.status == STAT_EMPTY && rsp.last))
		else $error("run on empty table gave no empty status");

endmodule
